>>> design/rational_arith_unit_macros.svh
// Assertion macros shared by the rational arithmetic unit modules.
// Included by the files that carry concurrent checks; no other dependency.
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH

// Same-cycle implication under the module's clock and reset.
`define RAU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under the module's clock and reset.
`define RAU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/rau_pkg.sv
// Shared types, constants and helper functions of the rational arithmetic unit.
// No dependencies; used by rau_mul, rau_div and rational_arith_unit.
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

   localparam int DW      = 32;          // port width of every signed field
   localparam int OPW     = 32;          // significant operand width, 8..32
   localparam int SH      = DW - OPW;
   localparam int WW      = 2 * DW;      // wide intermediate width
   localparam int DIV_CW  = $clog2(WW);

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_CMP = 3'd4
   } op_type;

   typedef struct packed {
      logic          start;
      logic [WW-1:0] dividend;
      logic [WW-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic          busy;
      logic          done;
      logic [WW-1:0] quot;
      logic [WW-1:0] rem;
   } div_sts_type;

   typedef struct packed {
      logic [DW-1:0] num;
      logic [DW-1:0] den;
      logic          greater;
      logic [DW-1:0] int_part;
      logic [DW-1:0] frac_rem;
      logic          whole;
      logic          err;
      logic          ovf;
   } res_type;

   // sign-extend a port word from bit OPW-1 to the wide width
   function automatic logic signed [WW-1:0] sx(input logic [DW-1:0] w);
      logic        [DW-1:0] t;
      logic signed [DW-1:0] s;
      t = w << SH;
      s = $signed(t) >>> SH;
      return {{(WW-DW){s[DW-1]}}, s};
   endfunction

   // wrap a wide value to OPW bits, sign-extended to the port width
   function automatic logic [DW-1:0] ow(input logic signed [WW-1:0] v);
      logic        [DW-1:0] t;
      logic signed [DW-1:0] s;
      t = v[DW-1:0] << SH;
      s = $signed(t) >>> SH;
      return s;
   endfunction

   function automatic logic fits(input logic signed [WW-1:0] v);
      return (&v[WW-1:OPW-1]) || !(|v[WW-1:OPW-1]);
   endfunction

   function automatic logic [WW-1:0] mag(input logic signed [WW-1:0] v);
      return v[WW-1] ? (WW'(0) - WW'(v)) : WW'(v);
   endfunction

   function automatic logic signed [WW-1:0] neg_if(input logic n,
                                                  input logic [WW-1:0] m);
      return n ? $signed(WW'(0) - m) : $signed(m);
   endfunction

endpackage

`default_nettype wire

>>> design/rational_arith_unit.sv
// Top level of the rational arithmetic unit: sequencer, work registers, output slot.
// Depends on rau_pkg, rau_mul, rau_div and rational_arith_unit_macros.svh.
//
//   channel | dir | tdata                                   | tuser
//   req     | in  | a_num, a_den, b_num, b_den (32 b each)  | req_type (3 b)
//   rsp     | out | res_num, res_den, greater, int_part,    | -
//           |     | frac_rem, is_whole, zero_den_error,     |
//           |     | overflow, zero pad to 136 b             |
//
// One item at a time. The three products run in turn through the one registered
// multiplier, then a sum state follows. Each Euclid step runs on the shared 64-bit divider
// (launch, a divide step per quotient bit, then the remainder is taken), at most about
// 92 steps; reducing takes two more divides and the integer part a third. Compare uses
// no divider. Reset is synchronous and clears control state only. A finished result
// waits in the output register while the next item is accepted; the sequencer stalls
// at its end until that slot is free.
`timescale 1ns / 1ps
`default_nettype none
`include "rational_arith_unit_macros.svh"

module rational_arith_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,  // a_num, a_den, b_num, b_den
   input  wire logic [2:0]   req_tuser,  // req_type
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // res_num, res_den, greater, int_part, frac_rem, is_whole, zero_den_error,
   // overflow, zero pad
   output logic [135:0]      rsp_tdata
);
   import rau_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_MUL   = 10'b0000000010,
      S_SUM   = 10'b0000000100,
      S_GCD   = 10'b0000001000,
      S_GWAIT = 10'b0000010000,
      S_NWAIT = 10'b0000100000,
      S_DWAIT = 10'b0001000000,
      S_CHK   = 10'b0010000000,
      S_QWAIT = 10'b0100000000,
      S_FIN   = 10'b1000000000
   } state_type;

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [DW-1:0]        an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [1:0]           mcnt_ff, mcnt_in;
   logic signed [WW-1:0] p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic signed [WW-1:0] num_ff, num_in, den_ff, den_in;
   logic signed [WW-1:0] x_ff, x_in, y_ff, y_in, g_ff, g_in;
   res_type              res_ff, res_in, out_ff, out_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic signed [WW-1:0] an_s, ad_s, bn_s, bd_s;
   logic signed [WW-1:0] sum_n, sum_d;
   logic signed [DW-1:0] mul_a, mul_b;
   logic signed [WW-1:0] prod;
   logic                 req_acc, den_eq;
   div_ctl_type          div_ctl;
   div_sts_type          div_sts;

   assign an_s    = sx(an_ff);
   assign ad_s    = sx(ad_ff);
   assign bn_s    = sx(bn_ff);
   assign bd_s    = sx(bd_ff);
   assign den_eq  = (ad_s == bd_s);
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc = req_tvalid && req_tready;

   // product order: left cross term, right cross term, denominator term
   always_comb begin
      case (mcnt_ff)
         2'd0: begin
            mul_a = an_s[DW-1:0];
            mul_b = (op_ff == OP_MUL) ? bn_s[DW-1:0] : bd_s[DW-1:0];
         end
         2'd1: begin
            mul_a = bn_s[DW-1:0];
            mul_b = ad_s[DW-1:0];
         end
         default: begin
            mul_a = ad_s[DW-1:0];
            mul_b = (op_ff == OP_DIV) ? bn_s[DW-1:0] : bd_s[DW-1:0];
         end
      endcase
   end

   rau_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   rau_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   always_comb begin
      case (op_ff)
         OP_ADD: begin
            sum_n = den_eq ? (an_s + bn_s) : (p0_ff + p1_ff);
            sum_d = den_eq ? ad_s : p2_ff;
         end
         OP_SUB: begin
            sum_n = den_eq ? (an_s - bn_s) : (p0_ff - p1_ff);
            sum_d = den_eq ? ad_s : p2_ff;
         end
         default: begin
            sum_n = p0_ff;
            sum_d = p2_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      an_in        = an_ff;
      ad_in        = ad_ff;
      bn_in        = bn_ff;
      bd_in        = bd_ff;
      mcnt_in      = mcnt_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      g_in         = g_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;
      div_ctl.start    = 1'b0;
      div_ctl.dividend = mag(num_ff);
      div_ctl.divisor  = mag(g_ff);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               op_in   = op_type'(req_tuser);
               an_in   = req_tdata[31:0];
               ad_in   = req_tdata[63:32];
               bn_in   = req_tdata[95:64];
               bd_in   = req_tdata[127:96];
               mcnt_in = 2'd0;
               res_in  = '0;
               state_in = (req_tuser > 3'(OP_CMP)) ? S_FIN : S_MUL;
            end
         end
         S_MUL: begin
            mcnt_in = mcnt_ff + 2'd1;
            case (mcnt_ff)
               2'd1: p0_in = prod;
               2'd2: p1_in = prod;
               2'd3: begin
                  p2_in    = prod;
                  state_in = S_SUM;
               end
               default: ;
            endcase
         end
         S_SUM: begin
            if (op_ff == OP_CMP) begin
               res_in.greater = den_eq ? (an_s > bn_s) : (p0_ff > p1_ff);
               state_in = S_FIN;
            end else begin
               num_in   = sum_n;
               den_in   = sum_d;
               x_in     = sum_n;
               y_in     = sum_d;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (x_ff == '0) begin
               if (y_ff == '0) begin
                  res_in.err = 1'b1;
                  state_in   = S_FIN;
               end else begin
                  g_in             = y_ff;
                  div_ctl.start    = 1'b1;
                  div_ctl.dividend = mag(num_ff);
                  div_ctl.divisor  = mag(y_ff);
                  state_in         = S_NWAIT;
               end
            end else begin
               div_ctl.start    = 1'b1;
               div_ctl.dividend = mag(y_ff);
               div_ctl.divisor  = mag(x_ff);
               state_in         = S_GWAIT;
            end
         end
         S_GWAIT: begin
            if (div_sts.done) begin
               // remainder keeps the sign of the dividend
               x_in     = neg_if(y_ff[WW-1], div_sts.rem);
               y_in     = x_ff;
               state_in = S_GCD;
            end
         end
         S_NWAIT: begin
            if (div_sts.done) begin
               num_in           = neg_if(num_ff[WW-1] ^ g_ff[WW-1], div_sts.quot);
               div_ctl.start    = 1'b1;
               div_ctl.dividend = mag(den_ff);
               div_ctl.divisor  = mag(g_ff);
               state_in         = S_DWAIT;
            end
         end
         S_DWAIT: begin
            if (div_sts.done) begin
               den_in   = neg_if(den_ff[WW-1] ^ g_ff[WW-1], div_sts.quot);
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            res_in.num = ow(num_ff);
            res_in.den = ow(den_ff);
            if (den_ff == '0) begin
               res_in.err = 1'b1;
               state_in   = S_FIN;
            end else if (!fits(num_ff) || !fits(den_ff)) begin
               res_in.ovf = 1'b1;
               state_in   = S_FIN;
            end else begin
               div_ctl.start    = 1'b1;
               div_ctl.dividend = mag(num_ff);
               div_ctl.divisor  = mag(den_ff);
               state_in         = S_QWAIT;
            end
         end
         S_QWAIT: begin
            if (div_sts.done) begin
               res_in.int_part = ow(neg_if(num_ff[WW-1] ^ den_ff[WW-1], div_sts.quot));
               res_in.frac_rem = ow(neg_if(num_ff[WW-1], div_sts.rem));
               res_in.whole    = (div_sts.rem == '0);
               state_in        = S_FIN;
            end
         end
         S_FIN: begin
            // hold until the output slot is free
            if (!rsp_valid_ff || rsp_tready) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mcnt_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mcnt_ff      <= mcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff  <= op_in;
      an_ff  <= an_in;
      ad_ff  <= ad_in;
      bn_ff  <= bn_in;
      bd_ff  <= bd_in;
      p0_ff  <= p0_in;
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      num_ff <= num_in;
      den_ff <= den_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      g_ff   <= g_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, out_ff.ovf, out_ff.err, out_ff.whole, out_ff.frac_rem,
                        out_ff.int_part, out_ff.greater, out_ff.den, out_ff.num};

   `RAU_ASSERT_NEXT(a_busy_after_acc, clock, reset, req_acc, !req_tready, "accepted item while busy")
   `RAU_ASSERT_NOW(a_err_ovf_excl, clock, reset, rsp_valid_ff, !(out_ff.err && out_ff.ovf), "error and overflow together")
   `RAU_ASSERT_NOW(a_err_no_int, clock, reset, rsp_valid_ff && out_ff.err, (out_ff.int_part == '0) && !out_ff.whole, "integer part on error")
   `RAU_ASSERT_NOW(a_div_only_wait, clock, reset, div_sts.done, (state_ff == S_GWAIT) || (state_ff == S_NWAIT) || (state_ff == S_DWAIT) || (state_ff == S_QWAIT), "divider done outside a wait state")

endmodule

`default_nettype wire

>>> design/rau_mul.sv
// Registered signed multiplier shared for all three products.
// Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rau_mul (
   input  wire logic                             clock,
   input  wire logic signed [rau_pkg::DW-1:0]    mul_a,
   input  wire logic signed [rau_pkg::DW-1:0]    mul_b,
   output logic signed      [rau_pkg::WW-1:0]    prod_ff
);
   import rau_pkg::*;

   logic signed [WW-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

>>> design/rau_div.sv
// Restoring unsigned divider, one quotient bit per cycle, wide operands.
// Depends on rau_pkg and rational_arith_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "rational_arith_unit_macros.svh"

module rau_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rau_pkg::div_ctl_type ctl,
   output rau_pkg::div_sts_type      sts
);
   import rau_pkg::*;

   logic [WW-1:0]     rem_ff, rem_in;
   logic [WW-1:0]     quot_ff, quot_in;
   logic [WW-1:0]     dsr_ff, dsr_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [WW:0]       shifted;
   logic [WW:0]       diff;

   always_comb begin
      shifted = {rem_ff, quot_ff[WW-1]};
      diff    = shifted - {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         rem_in  = '0;
         quot_in = ctl.dividend;
         dsr_in  = ctl.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = diff[WW] ? shifted[WW-1:0] : diff[WW-1:0];
         quot_in = {quot_ff[WW-2:0], ~diff[WW]};
         cnt_in  = cnt_ff + DIV_CW'(1);
         if (cnt_ff == DIV_CW'(WW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dsr_ff  <= dsr_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign sts.quot = quot_ff;
   assign sts.rem  = rem_ff;

   `RAU_ASSERT_NOW(a_start_idle, clock, reset, ctl.start, !busy_ff, "divider restarted while busy")
   `RAU_ASSERT_NOW(a_done_idle, clock, reset, done_ff, !busy_ff, "divider done while busy")
   `RAU_ASSERT_NEXT(a_last_done, clock, reset, busy_ff && !ctl.start && (cnt_ff == DIV_CW'(WW - 1)), done_ff, "divider missed done")

endmodule

`default_nettype wire
